@@ sv/bfct_pkg.sv @@
`timescale 1ns / 1ps

package bfct_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_DUMP   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // result status codes
   localparam logic [2:0] STAT_IGNORED = 3'd0;
   localparam logic [2:0] STAT_NEW     = 3'd1;
   localparam logic [2:0] STAT_UPDATED = 3'd2;
   localparam logic [2:0] STAT_DROPPED = 3'd3;
   localparam logic [2:0] STAT_ENTRY   = 3'd4;
   localparam logic [2:0] STAT_EMPTY   = 3'd5;
   localparam logic [2:0] STAT_CLEARED = 3'd6;

   // protocol classes
   localparam logic [2:0] CLS_OTHER = 3'd0;
   localparam logic [2:0] CLS_TCP   = 3'd1;
   localparam logic [2:0] CLS_UDP   = 3'd2;
   localparam logic [2:0] CLS_ICMP  = 3'd3;
   localparam logic [2:0] CLS_IGMP  = 3'd4;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;

   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_IGMP = 8'd2;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam int DEF_TABLE_DEPTH = 32;
   localparam int MAX_RESULTS     = 32;

   // one table entry as held in the flow memory
   typedef struct packed {
      logic        family;
      logic [2:0]  cls;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [31:0] ports;
      logic [63:0] sent;
      logic [63:0] received;
      logic [63:0] packets;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPD,
      ST_DSCAN,
      ST_DOUT
   } state_type;

endpackage

@@ sv/bfct_ram.sv @@
`timescale 1ns / 1ps

module bfct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bidirectional_flow_counter_table_unit.sv @@
`timescale 1ns / 1ps
// Bidirectional flow counter table.
// Input channel: an item (req_* ports) is taken at a rising edge with start
// high and busy low. Operation packet matches the header against the flow
// table in either direction and adds (or, if full, drops) or updates a flow;
// dump reports the flows largest total first; clear empties the table.
// Result channel: each result item is on the rsp_* ports for one cycle with
// rsp_strobe high; rsp_last marks the final result of an item. The receiver
// cannot stall, so results are never held back.
// Timing: ignored frames, clear and a dump of an empty table give their
// result in the cycle after acceptance. A packet scans the stored flows
// one memory read per cycle until a match or the last flow. A dump takes
// one full scan per reported flow. The single read port of the flow memory
// is why a scan reads one flow at a time. busy is high for the whole of
// that work; start is taken again in the cycle of the last result.
// Reset: the flow count returns to zero, giving an empty table; the memory
// itself is not cleared, so no clearing pass is needed.
module bidirectional_flow_counter_table_unit
   import bfct_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_ether_type,
   input  logic [7:0]  req_next_protocol,
   input  logic [63:0] req_source_high,
   input  logic [63:0] req_source_low,
   input  logic [63:0] req_dest_high,
   input  logic [63:0] req_dest_low,
   input  logic [31:0] req_transport_word,
   input  logic [15:0] req_frame_length,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   output logic        rsp_is_ipv6,
   output logic [2:0]  rsp_proto_class,
   output logic [63:0] rsp_flow_src_high,
   output logic [63:0] rsp_flow_src_low,
   output logic [63:0] rsp_flow_dst_high,
   output logic [63:0] rsp_flow_dst_low,
   output logic [31:0] rsp_flow_ports,
   output logic [63:0] rsp_sent_bytes,
   output logic [63:0] rsp_received_bytes,
   output logic [63:0] rsp_packet_total
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic        cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   entry_type   pkt_ff, pkt_in;
   logic [15:0] len_ff, len_in;
   entry_type   hit_ff, hit_in;
   logic        hit_fwd_ff, hit_fwd_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [CW-1:0] pass_ff, pass_in;
   logic [64:0] prev_total_ff, prev_total_in;
   logic [AW-1:0] prev_idx_ff, prev_idx_in;
   logic        best_vld_ff, best_vld_in;
   logic [64:0] best_total_ff, best_total_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   entry_type   best_ff, best_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;
   entry_type   rsp_entry_ff, rsp_entry_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type     rd_entry;

   entry_type   req_key;
   logic        req_valid_family;
   logic        accept;
   logic        fwd_hit, bwd_hit, any_hit;
   logic        scan_done;
   logic [64:0] rd_total;
   logic        eligible, better;
   logic        dump_last;
   int          shown;

   bfct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_flow_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);

   // header decode into a key
   always_comb begin
      req_key          = '0;
      req_valid_family = (req_ether_type == ETH_IPV4) || (req_ether_type == ETH_IPV6);
      req_key.family   = (req_ether_type == ETH_IPV6);
      if (req_key.family) begin
         req_key.src_high = req_source_high;
         req_key.src_low  = req_source_low;
         req_key.dst_high = req_dest_high;
         req_key.dst_low  = req_dest_low;
      end else begin
         req_key.src_low = {32'd0, req_source_low[31:0]};
         req_key.dst_low = {32'd0, req_dest_low[31:0]};
      end
      case (req_next_protocol)
         PROTO_TCP: begin
            req_key.cls   = CLS_TCP;
            req_key.ports = req_transport_word;
         end
         PROTO_UDP: begin
            req_key.cls   = CLS_UDP;
            req_key.ports = req_transport_word;
         end
         PROTO_ICMP: req_key.cls = CLS_ICMP;
         PROTO_IGMP: req_key.cls = CLS_IGMP;
         default:    req_key.cls = CLS_OTHER;
      endcase
   end

   // key compare on the entry just read, both directions
   always_comb begin
      fwd_hit = (rd_entry.family == pkt_ff.family) &&
                (rd_entry.src_high == pkt_ff.src_high) &&
                (rd_entry.src_low == pkt_ff.src_low) &&
                (rd_entry.dst_high == pkt_ff.dst_high) &&
                (rd_entry.dst_low == pkt_ff.dst_low) &&
                (rd_entry.ports == pkt_ff.ports);
      bwd_hit = (rd_entry.family == pkt_ff.family) &&
                (rd_entry.src_high == pkt_ff.dst_high) &&
                (rd_entry.src_low == pkt_ff.dst_low) &&
                (rd_entry.dst_high == pkt_ff.src_high) &&
                (rd_entry.dst_low == pkt_ff.src_low) &&
                (rd_entry.ports == {pkt_ff.ports[15:0], pkt_ff.ports[31:16]});
      any_hit = cmp_vld_ff && (fwd_hit || bwd_hit);
      scan_done = !cmp_vld_ff && (rd_idx_ff == count_ff);
   end

   // ranking of the entry just read against the last one reported
   always_comb begin
      rd_total = {1'b0, rd_entry.sent} + {1'b0, rd_entry.received};
      eligible = (pass_ff == '0) || (rd_total < prev_total_ff) ||
                 ((rd_total == prev_total_ff) && (cmp_idx_ff > prev_idx_ff));
      better   = cmp_vld_ff && eligible && (!best_vld_ff || (rd_total > best_total_ff));
      shown    = (int'(count_ff) > MAX_RESULTS) ? MAX_RESULTS : int'(count_ff);
      dump_last = (int'(pass_ff) + 1 == shown);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_PACKET && req_valid_family) begin
                  state_in = ST_SCAN;
               end else if (req_operation == OP_DUMP && count_ff != '0) begin
                  state_in = ST_DSCAN;
               end
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               state_in = ST_UPD;
            end else if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD:   state_in = ST_IDLE;
         ST_DSCAN: begin
            if (scan_done) begin
               state_in = ST_DOUT;
            end
         end
         ST_DOUT:  state_in = dump_last ? ST_IDLE : ST_DSCAN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath, memory write and result registers
   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      pkt_in        = pkt_ff;
      len_in        = len_ff;
      hit_in        = hit_ff;
      hit_fwd_in    = hit_fwd_ff;
      hit_idx_in    = hit_idx_ff;
      pass_in       = pass_ff;
      prev_total_in = prev_total_ff;
      prev_idx_in   = prev_idx_ff;
      best_vld_in   = best_vld_ff;
      best_total_in = best_total_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_entry_in  = rsp_entry_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = hit_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_idx_in   = '0;
            pass_in     = '0;
            best_vld_in = 1'b0;
            if (accept) begin
               pkt_in = req_key;
               len_in = req_frame_length;
               if (req_operation == OP_PACKET && req_valid_family) begin
                  // table scan follows
               end else if (req_operation == OP_DUMP && count_ff != '0) begin
                  // dump passes follow
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_entry_in  = '0;
                  case (req_operation)
                     OP_DUMP:  rsp_status_in = STAT_EMPTY;
                     OP_CLEAR: begin
                        rsp_status_in = STAT_CLEARED;
                        count_in      = '0;
                     end
                     default:  rsp_status_in = STAT_IGNORED;
                  endcase
               end
            end
         end

         ST_SCAN: begin
            if (any_hit) begin
               hit_in     = rd_entry;
               hit_fwd_in = fwd_hit;
               hit_idx_in = cmp_idx_ff;
            end else if (scan_done) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_entry_in  = pkt_ff;
               if (int'(count_ff) >= TABLE_DEPTH) begin
                  rsp_status_in         = STAT_DROPPED;
                  rsp_entry_in.sent     = '0;
                  rsp_entry_in.received = '0;
                  rsp_entry_in.packets  = '0;
               end else begin
                  rsp_status_in         = STAT_NEW;
                  rsp_entry_in.sent     = {48'd0, len_ff};
                  rsp_entry_in.received = '0;
                  rsp_entry_in.packets  = 64'd1;
                  wr_en                 = 1'b1;
                  wr_addr               = count_ff[AW-1:0];
                  wr_data               = rsp_entry_in;
                  count_in              = count_ff + 1'b1;
               end
            end else if (rd_idx_ff != count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end

         // counter update of the matched flow, written back
         ST_UPD: begin
            wr_data = hit_ff;
            if (hit_fwd_ff) begin
               wr_data.sent = hit_ff.sent + {48'd0, len_ff};
            end else begin
               wr_data.received = hit_ff.received + {48'd0, len_ff};
            end
            wr_data.packets = hit_ff.packets + 64'd1;
            wr_en           = 1'b1;
            wr_addr         = hit_idx_ff;
            rsp_strobe_in   = 1'b1;
            rsp_last_in     = 1'b1;
            rsp_status_in   = STAT_UPDATED;
            rsp_entry_in    = wr_data;
         end

         // one pass picks the next flow in rank order
         ST_DSCAN: begin
            if (better) begin
               best_vld_in   = 1'b1;
               best_total_in = rd_total;
               best_idx_in   = cmp_idx_ff;
               best_in       = rd_entry;
            end
            if (rd_idx_ff != count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[AW-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end

         ST_DOUT: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = dump_last;
            rsp_status_in = STAT_ENTRY;
            rsp_entry_in  = best_ff;
            prev_total_in = best_total_ff;
            prev_idx_in   = best_idx_ff;
            pass_in       = pass_ff + 1'b1;
            best_vld_in   = 1'b0;
            rd_idx_in     = '0;
         end

         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         pass_ff       <= '0;
         best_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         pass_ff       <= pass_in;
         best_vld_ff   <= best_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      pkt_ff        <= pkt_in;
      len_ff        <= len_in;
      hit_ff        <= hit_in;
      hit_fwd_ff    <= hit_fwd_in;
      hit_idx_ff    <= hit_idx_in;
      prev_total_ff <= prev_total_in;
      prev_idx_ff   <= prev_idx_in;
      best_total_ff <= best_total_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_is_ipv6        = rsp_entry_ff.family;
   assign rsp_proto_class    = rsp_entry_ff.cls;
   assign rsp_flow_src_high  = rsp_entry_ff.src_high;
   assign rsp_flow_src_low   = rsp_entry_ff.src_low;
   assign rsp_flow_dst_high  = rsp_entry_ff.dst_high;
   assign rsp_flow_dst_low   = rsp_entry_ff.dst_low;
   assign rsp_flow_ports     = rsp_entry_ff.ports;
   assign rsp_sent_bytes     = rsp_entry_ff.sent;
   assign rsp_received_bytes = rsp_entry_ff.received;
   assign rsp_packet_total   = rsp_entry_ff.packets;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import bfct_pkg::*;

   // one request item
   typedef struct {
      logic [1:0]  op;
      logic [15:0] eth;
      logic [7:0]  proto;
      logic [63:0] sh, sl, dh, dl;
      logic [31:0] tw;
      logic [15:0] len;
   } req_item_type;

   // one result item
   typedef struct {
      logic [2:0]  status;
      logic        last;
      logic        v6;
      logic [2:0]  cls;
      logic [63:0] sh, sl, dh, dl;
      logic [31:0] ports;
      logic [63:0] sent, rcvd, pkts;
   } flow_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_ether_type = '0;
   logic [7:0]  req_next_protocol = '0;
   logic [63:0] req_source_high = '0, req_source_low = '0;
   logic [63:0] req_dest_high = '0, req_dest_low = '0;
   logic [31:0] req_transport_word = '0;
   logic [15:0] req_frame_length = '0;
   logic        rsp_strobe, rsp_last, rsp_is_ipv6;
   logic [2:0]  rsp_status, rsp_proto_class;
   logic [63:0] rsp_flow_src_high, rsp_flow_src_low, rsp_flow_dst_high, rsp_flow_dst_low;
   logic [31:0] rsp_flow_ports;
   logic [63:0] rsp_sent_bytes, rsp_received_bytes, rsp_packet_total;

   bidirectional_flow_counter_table_unit i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor copy of the flow table
   flow_rsp_type flows [DEF_TABLE_DEPTH];
   int           n_flows = 0;
   req_item_type pending_reqs[$];
   flow_rsp_type expected_rsps[$];
   int           n_errors = 0;
   int           idle_pct = 20;
   bit           stim_done = 1'b0;
   bit           hold_sender = 1'b0;

   function automatic flow_rsp_type status_only(logic [2:0] s);
      flow_rsp_type r;
      r = '{default: '0};
      r.status = s;
      r.last = 1'b1;
      return r;
   endfunction

   // append to the tail of the pending and expected queues
   task automatic queue_req(input req_item_type q);
      pending_reqs.insert(pending_reqs.size(), q);
   endtask

   task automatic queue_exp(input flow_rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // 65-bit total ranking, ties by insertion order
   function automatic bit ranks_ahead(int a, int b);
      logic [64:0] ta, tb;
      ta = {1'b0, flows[a].sent} + {1'b0, flows[a].rcvd};
      tb = {1'b0, flows[b].sent} + {1'b0, flows[b].rcvd};
      if (ta != tb) return ta > tb;
      return a < b;
   endfunction

   task automatic predict_flow_table(input req_item_type q);
      flow_rsp_type r;
      logic [63:0] sh, sl, dh, dl;
      logic [31:0] ports, rev;
      logic [2:0]  cls;
      bit          v6, fwd, bwd;
      int          rank [DEF_TABLE_DEPTH];
      if (q.op == OP_CLEAR) begin
         n_flows = 0;
         queue_exp(status_only(STAT_CLEARED));
      end else if (q.op == OP_DUMP) begin
         if (n_flows == 0) begin
            queue_exp(status_only(STAT_EMPTY));
         end else begin
            for (int i = 0; i < n_flows; i++) begin
               rank[i] = 0;
               for (int j = 0; j < n_flows; j++)
                  if (j != i && ranks_ahead(j, i)) rank[i]++;
            end
            for (int k = 0; k < n_flows; k++)
               for (int i = 0; i < n_flows; i++)
                  if (rank[i] == k) begin
                     r = flows[i];
                     r.status = STAT_ENTRY;
                     r.last = (k == n_flows - 1);
                     queue_exp(r);
                  end
         end
      end else if (q.op != OP_PACKET ||
                   (q.eth != ETH_IPV4 && q.eth != ETH_IPV6)) begin
         queue_exp(status_only(STAT_IGNORED));
      end else begin
         v6 = (q.eth == ETH_IPV6);
         sh = v6 ? q.sh : '0;
         dh = v6 ? q.dh : '0;
         sl = v6 ? q.sl : {32'd0, q.sl[31:0]};
         dl = v6 ? q.dl : {32'd0, q.dl[31:0]};
         ports = '0;
         cls = CLS_OTHER;
         if (q.proto == PROTO_TCP || q.proto == PROTO_UDP) begin
            ports = q.tw;
            cls = (q.proto == PROTO_TCP) ? CLS_TCP : CLS_UDP;
         end else if (q.proto == PROTO_ICMP) cls = CLS_ICMP;
         else if (q.proto == PROTO_IGMP) cls = CLS_IGMP;
         rev = {ports[15:0], ports[31:16]};
         for (int i = 0; i < n_flows; i++) begin
            if (flows[i].v6 != v6) continue;
            fwd = flows[i].sh == sh && flows[i].sl == sl && flows[i].dh == dh &&
                  flows[i].dl == dl && flows[i].ports == ports;
            bwd = flows[i].sh == dh && flows[i].sl == dl && flows[i].dh == sh &&
                  flows[i].dl == sl && flows[i].ports == rev;
            if (fwd || bwd) begin
               if (fwd) flows[i].sent += q.len;
               else flows[i].rcvd += q.len;
               flows[i].pkts += 1;
               r = flows[i];
               r.status = STAT_UPDATED;
               r.last = 1'b1;
               queue_exp(r);
               return;
            end
         end
         r = '{default: '0};
         r.last = 1'b1; r.v6 = v6; r.cls = cls;
         r.sh = sh; r.sl = sl; r.dh = dh; r.dl = dl; r.ports = ports;
         if (n_flows >= DEF_TABLE_DEPTH) begin
            r.status = STAT_DROPPED;
         end else begin
            r.sent = q.len; r.pkts = 1;
            flows[n_flows] = r;
            n_flows++;
            r.status = STAT_NEW;
         end
         queue_exp(r);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got, exp_v);
      n_errors++;
      $display("mismatch %s: got %h expected %h", what, got, exp_v);
   endtask

   // driver: one item per handshake, random gaps
   always @(posedge clock) begin
      req_item_type q;
      if (!reset) begin
         if (start && !busy) begin
            q = pending_reqs.pop_front();
            predict_flow_table(q);
         end
         if ((start && !busy) || !start) begin
            if (pending_reqs.size() > 0 && !hold_sender &&
                $urandom_range(99, 0) >= idle_pct) begin
               q = pending_reqs[0];
               start <= 1'b1;
               req_operation <= q.op;
               req_ether_type <= q.eth;
               req_next_protocol <= q.proto;
               req_source_high <= q.sh;
               req_source_low <= q.sl;
               req_dest_high <= q.dh;
               req_dest_low <= q.dl;
               req_transport_word <= q.tw;
               req_frame_length <= q.len;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      flow_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", rsp_status, '0);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
            if (rsp_is_ipv6 !== e.v6) report_mismatch("is_ipv6", rsp_is_ipv6, e.v6);
            if (rsp_proto_class !== e.cls) report_mismatch("class", rsp_proto_class, e.cls);
            if (rsp_flow_src_high !== e.sh) report_mismatch("src_high", rsp_flow_src_high, e.sh);
            if (rsp_flow_src_low !== e.sl) report_mismatch("src_low", rsp_flow_src_low, e.sl);
            if (rsp_flow_dst_high !== e.dh) report_mismatch("dst_high", rsp_flow_dst_high, e.dh);
            if (rsp_flow_dst_low !== e.dl) report_mismatch("dst_low", rsp_flow_dst_low, e.dl);
            if (rsp_flow_ports !== e.ports) report_mismatch("ports", rsp_flow_ports, e.ports);
            if (rsp_sent_bytes !== e.sent) report_mismatch("sent", rsp_sent_bytes, e.sent);
            if (rsp_received_bytes !== e.rcvd)
               report_mismatch("received", rsp_received_bytes, e.rcvd);
            if (rsp_packet_total !== e.pkts) report_mismatch("packets", rsp_packet_total, e.pkts);
         end
      end
   end

   // small address pool so flows repeat and reverse
   logic [63:0] pool_h [4];
   logic [63:0] pool_l [4];
   logic [15:0] port_pool [3];

   function automatic req_item_type pkt(logic [15:0] eth, logic [7:0] pr, logic [63:0] sh, sl,
                                        dh, dl, logic [31:0] tw, logic [15:0] len);
      req_item_type q;
      q.op = OP_PACKET; q.eth = eth; q.proto = pr;
      q.sh = sh; q.sl = sl; q.dh = dh; q.dl = dl; q.tw = tw; q.len = len;
      return q;
   endfunction

   function automatic req_item_type ctl(logic [1:0] op);
      req_item_type q;
      q = pkt(16'hFFFF, '1, '1, '1, '1, '1, '1, '1);
      q.op = op;
      return q;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_item_type random_item(int slots);
      req_item_type q;
      int        a, b, k;
      logic [7:0] protos [6];
      logic [15:0] p1, p2;
      protos = '{PROTO_TCP, PROTO_UDP, PROTO_ICMP, PROTO_IGMP, 8'd0, 8'd255};
      k = $urandom_range(99, 0);
      if (k < 4) return ctl(OP_DUMP);
      if (k < 6) return ctl(OP_CLEAR);
      if (k < 8) begin
         q = pkt(16'(rnd64()), 8'(rnd64()), rnd64(), rnd64(), rnd64(), rnd64(),
                 $urandom(), 16'(rnd64()));
         q.op = 2'(k[0] ? 3 : 0);
         return q;
      end
      a = $urandom_range(slots - 1, 0);
      b = $urandom_range(slots - 1, 0);
      p1 = port_pool[$urandom_range(2, 0)];
      p2 = port_pool[$urandom_range(2, 0)];
      q = pkt($urandom_range(1, 0) ? ETH_IPV6 : ETH_IPV4, protos[$urandom_range(5, 0)],
              pool_h[a], pool_l[a], pool_h[b], pool_l[b], {p1, p2},
              $urandom_range(3, 0) == 0 ? 16'hFFFF : 16'($urandom()));
      // high bits are noise for IPv4
      if (q.eth == ETH_IPV4 && $urandom_range(1, 0)) begin
         q.sh = rnd64(); q.dh = rnd64();
         q.sl[63:32] = $urandom(); q.dl[63:32] = $urandom();
      end
      if ($urandom_range(1, 0)) begin
         {q.sh, q.sl, q.dh, q.dl} = {q.dh, q.dl, q.sh, q.sl};
         q.tw = {q.tw[15:0], q.tw[31:16]};
      end
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start || busy)
         @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 4; i++) begin
         pool_h[i] = rnd64();
         pool_l[i] = rnd64();
      end
      pool_h[0] = '1; pool_l[0] = '1; pool_h[1] = '0; pool_l[1] = '0;
      port_pool = '{16'h0000, 16'hFFFF, 16'($urandom())};

      // directed: empty dump, ignored frames, extremes, both directions, clear
      queue_req(ctl(OP_DUMP));
      queue_req(pkt(16'h0000, PROTO_TCP, '1, '1, '1, '1, '1, 16'hFFFF));
      queue_req(ctl(2'd3));
      queue_req(pkt(ETH_IPV4, PROTO_TCP, '1, '1, '0, '0, 32'hFFFF0000, 16'hFFFF));
      queue_req(pkt(ETH_IPV4, PROTO_TCP, '0, '0, '1, '1, 32'h0000FFFF, 16'h0000));
      queue_req(pkt(ETH_IPV4, PROTO_UDP, '0, '0, '1, '1, 32'h0000FFFF, 16'd64));
      queue_req(pkt(ETH_IPV6, PROTO_ICMP, '1, '1, '0, '0, 32'h12345678, 16'hFFFF));
      queue_req(pkt(ETH_IPV6, PROTO_IGMP, '0, '0, '1, '1, 32'h0, 16'd10));
      queue_req(pkt(ETH_IPV6, 8'd255, '1, '0, '0, '1, '1, 16'd1));
      queue_req(pkt(ETH_IPV6, PROTO_UDP, '1, '0, '0, '1, 32'hABCD1234, 16'd5));
      queue_req(pkt(ETH_IPV6, PROTO_UDP, '0, '1, '1, '0, 32'h1234ABCD, 16'd7));
      queue_req(ctl(OP_DUMP));
      queue_req(ctl(OP_CLEAR));
      queue_req(ctl(OP_DUMP));
      // fill the table past full, then a dump of 32
      for (int i = 0; i < 34; i++)
         queue_req(pkt(ETH_IPV6, PROTO_TCP, rnd64(), rnd64(), rnd64(), rnd64(),
                       $urandom(), 16'($urandom())));
      queue_req(ctl(OP_DUMP));
      queue_req(ctl(OP_CLEAR));
      wait_drained();

      // sender is held back while the next items are queued, then released
      hold_sender = 1'b1;
      for (int i = 0; i < 5; i++) queue_req(random_item(4));
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();

      // random phases: sender idles 20%, then 72%, then not at all
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 20 : (phase == 1) ? 72 : 0;
         for (int i = 0; i < 140; i++) queue_req(random_item(4));
         queue_req(ctl(OP_DUMP));
         wait_drained();
      end
      stim_done = 1'b1;
      repeat (50) @(posedge clock);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
